// ===== sv/pad_pkg.sv =====
// Package with shared types, codes and reset values for the phase-angle dimmer.
package pad_pkg;

	localparam int LEVEL_BITS_DEF = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int OUT_LEVEL_W    = 8;

	localparam logic [7:0]  FULL_ON_LEVEL_RST  = 8'd0;
	localparam logic [7:0]  RAMP_UP_START_RST  = 8'd100;
	localparam logic [7:0]  OFF_LEVEL_RST      = 8'd128;
	localparam logic [15:0] TICKS_PER_STEP_RST = 16'd60;
	localparam logic [7:0]  RAMP_STEPS_RST     = 8'd30;
	localparam logic [7:0]  STEP_MAX           = 8'hFF;

	typedef enum logic [2:0] {
		CMD_ZERO_CROSS = 3'd0,
		CMD_PHASE_TICK = 3'd1,
		CMD_RAMP_TICK  = 3'd2,
		CMD_RAMP_UP    = 3'd3,
		CMD_RAMP_DOWN  = 3'd4,
		CMD_SET_LEVEL  = 3'd5
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FULL_ON_LEVEL  = 3'd0,
		CFG_RAMP_UP_START  = 3'd1,
		CFG_OFF_LEVEL      = 3'd2,
		CFG_TICKS_PER_STEP = 3'd3,
		CFG_RAMP_STEPS     = 3'd4
	} cfg_idx_e;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] new_level;
	} item_t;

	typedef struct packed {
		logic       gate;
		logic [7:0] delay_level;
		logic       ramping;
		logic       light_on_event;
		logic       light_off_event;
	} result_t;

	typedef struct packed {
		logic [7:0]  full_on_level;
		logic [7:0]  ramp_up_start;
		logic [7:0]  off_level;
		logic [15:0] ticks_per_step;
		logic [7:0]  ramp_steps;
	} cfg_t;

	typedef struct packed {
		logic ramping;
		logic light_on_event;
		logic light_off_event;
	} ramp_flags_t;

endpackage

// ===== sv/phase_angle_dimmer_with_ramp.sv =====
// Top level of the phase-angle triac dimmer with brightening and darkening ramps.
//
// Every input transaction carries one command (zero cross, phase tick, ramp tick,
// start ramp up, start ramp down or set level) and yields exactly one result
// transaction with the gate drive, the delay level, the ramp status and the
// light on and light off events.
// An accepted command lands in the input register; once the output register is
// free or being read, the dimmer state is updated from it and the result is
// written to the output register, where it is offered. One command per cycle is
// sustained while the receiver takes results; the rate is set by the single
// compare and increment stage between the two registers.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more command; item_ready falls only when
// both registers are full.
// The configuration port writes one register per cycle with cfg_we and must
// only be used while no transaction is in flight.
// Reset clears the pipeline, disarms the phase counter, drops the gate, stops
// both ramps, sets the level to zero and restores the register defaults.
module phase_angle_dimmer_with_ramp #(
	parameter int LEVEL_BITS = pad_pkg::LEVEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  pad_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output pad_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [pad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pad_pkg::*;

	item_t                 item_s1;
	logic                  valid_s1;
	result_t               result_s2;
	logic                  valid_s2;
	logic                  fire;
	cfg_t                  cfg;
	logic                  gate_nxt;
	logic [LEVEL_BITS-1:0] level;
	logic [LEVEL_BITS-1:0] level_nxt;
	ramp_flags_t           flags;

	assign fire       = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2.gate            <= gate_nxt;
			result_s2.delay_level     <= OUT_LEVEL_W'(level_nxt);
			result_s2.ramping         <= flags.ramping;
			result_s2.light_on_event  <= flags.light_on_event;
			result_s2.light_off_event <= flags.light_off_event;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	pad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pad_phase #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.command  (item_s1.command),
		.level    (level),
		.gate_nxt (gate_nxt)
	);

	pad_ramp #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.command   (item_s1.command),
		.new_level (item_s1.new_level),
		.cfg       (cfg),
		.level     (level),
		.level_nxt (level_nxt),
		.flags     (flags)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result_ready |-> !item_ready)
		else $error("Input register accepts while the pipeline is full.");

	a_ramp_up_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.command == CMD_RAMP_UP
		|=> valid_s2 && result_s2.light_on_event && result_s2.ramping)
		else $error("Ramp up start did not produce its event.");

	a_zero_cross_gate: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.command == CMD_ZERO_CROSS |=> !result_s2.gate)
		else $error("Gate not dropped on zero cross.");

	a_off_event_stops: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.light_off_event |-> !result_s2.ramping)
		else $error("Ramp still active after ramp down completion.");

endmodule

// ===== sv/pad_cfg.sv =====
// Configuration register file of the phase-angle dimmer.
module pad_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pad_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pad_pkg::cfg_t                      cfg
);
	import pad_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_on_level  <= FULL_ON_LEVEL_RST;
			cfg_q.ramp_up_start  <= RAMP_UP_START_RST;
			cfg_q.off_level      <= OFF_LEVEL_RST;
			cfg_q.ticks_per_step <= TICKS_PER_STEP_RST;
			cfg_q.ramp_steps     <= RAMP_STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FULL_ON_LEVEL:  cfg_q.full_on_level  <= cfg_data[7:0];
				CFG_RAMP_UP_START:  cfg_q.ramp_up_start  <= cfg_data[7:0];
				CFG_OFF_LEVEL:      cfg_q.off_level      <= cfg_data[7:0];
				CFG_TICKS_PER_STEP: cfg_q.ticks_per_step <= cfg_data;
				CFG_RAMP_STEPS:     cfg_q.ramp_steps     <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/pad_phase.sv =====
// Zero-cross arming, phase counter and triac gate drive.
module pad_phase #(
	parameter int LEVEL_BITS = pad_pkg::LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [2:0]            command,
	input  logic [LEVEL_BITS-1:0] level,
	output logic                  gate_nxt
);
	import pad_pkg::*;

	logic                  armed_q, armed_n;
	logic                  gate_q, gate_n;
	logic [LEVEL_BITS-1:0] phase_q, phase_n;

	always_comb begin
		armed_n = armed_q;
		gate_n  = gate_q;
		phase_n = phase_q;
		case (command)
			CMD_ZERO_CROSS: begin
				armed_n = 1'b1;
				phase_n = '0;
				gate_n  = 1'b0;
			end
			CMD_PHASE_TICK: begin
				if (armed_q) begin
					if (phase_q >= level) begin
						gate_n  = 1'b1;
						phase_n = '0;
						armed_n = 1'b0;
					end else begin
						phase_n = phase_q + 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			gate_q  <= 1'b0;
			phase_q <= '0;
		end else if (fire) begin
			armed_q <= armed_n;
			gate_q  <= gate_n;
			phase_q <= phase_n;
		end
	end

	assign gate_nxt = gate_n;

endmodule

// ===== sv/pad_ramp.sv =====
// Delay level register with the brightening and darkening ramp sequencer.
module pad_ramp #(
	parameter int LEVEL_BITS = pad_pkg::LEVEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [2:0]            command,
	input  logic [7:0]            new_level,
	input  pad_pkg::cfg_t         cfg,
	output logic [LEVEL_BITS-1:0] level,
	output logic [LEVEL_BITS-1:0] level_nxt,
	output pad_pkg::ramp_flags_t  flags
);
	import pad_pkg::*;

	localparam int SUM_W = (LEVEL_BITS > 9) ? LEVEL_BITS : 9;

	logic [LEVEL_BITS-1:0] level_q, level_n;
	logic                  up_q, up_n;
	logic                  down_q, down_n;
	logic [15:0]           sub_q, sub_n;
	logic [7:0]            step_q, step_n;

	logic [15:0]           sub_inc;
	logic                  wrap;
	logic [15:0]           sub_tick;
	logic [7:0]            step_tick;
	logic                  done;
	logic [LEVEL_BITS-1:0] up_lvl;
	logic [SUM_W-1:0]      dn_sum;
	logic [SUM_W-1:0]      lvl_max;
	logic [LEVEL_BITS-1:0] dn_lvl;
	logic                  on_ev, off_ev;

	assign sub_inc   = sub_q + 16'd1;
	assign wrap      = sub_inc >= cfg.ticks_per_step;
	assign sub_tick  = wrap ? 16'd0 : sub_inc;
	assign step_tick = (wrap && step_q != STEP_MAX) ? step_q + 8'd1 : step_q;
	assign done      = step_tick >= cfg.ramp_steps;

	assign up_lvl  = (cfg.ramp_up_start > step_tick)
		? LEVEL_BITS'(cfg.ramp_up_start - step_tick) : '0;
	assign dn_sum  = SUM_W'(cfg.full_on_level) + SUM_W'(step_tick);
	assign lvl_max = SUM_W'({LEVEL_BITS{1'b1}});
	assign dn_lvl  = (dn_sum > lvl_max) ? '1 : dn_sum[LEVEL_BITS-1:0];

	always_comb begin
		level_n = level_q;
		up_n    = up_q;
		down_n  = down_q;
		sub_n   = sub_q;
		step_n  = step_q;
		on_ev   = 1'b0;
		off_ev  = 1'b0;
		case (command)
			CMD_RAMP_TICK: begin
				if (up_q || down_q) begin
					if (done) begin
						if (up_q) begin
							level_n = LEVEL_BITS'(cfg.full_on_level);
							up_n    = 1'b0;
						end
						if (down_q) begin
							level_n = LEVEL_BITS'(cfg.off_level);
							down_n  = 1'b0;
							off_ev  = 1'b1;
						end
						sub_n  = '0;
						step_n = '0;
					end else begin
						sub_n  = sub_tick;
						step_n = step_tick;
						if (up_q) begin
							level_n = up_lvl;
						end
						if (down_q) begin
							level_n = dn_lvl;
						end
					end
				end
			end
			CMD_RAMP_UP: begin
				level_n = LEVEL_BITS'(cfg.ramp_up_start);
				sub_n   = '0;
				step_n  = '0;
				up_n    = 1'b1;
				on_ev   = 1'b1;
			end
			CMD_RAMP_DOWN: begin
				level_n = LEVEL_BITS'(cfg.full_on_level);
				sub_n   = '0;
				step_n  = '0;
				down_n  = 1'b1;
			end
			CMD_SET_LEVEL: begin
				level_n = LEVEL_BITS'(new_level);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_BITS'(FULL_ON_LEVEL_RST);
			up_q    <= 1'b0;
			down_q  <= 1'b0;
			sub_q   <= '0;
			step_q  <= '0;
		end else if (fire) begin
			level_q <= level_n;
			up_q    <= up_n;
			down_q  <= down_n;
			sub_q   <= sub_n;
			step_q  <= step_n;
		end
	end

	assign level                 = level_q;
	assign level_nxt             = level_n;
	assign flags.ramping         = up_n || down_n;
	assign flags.light_on_event  = on_ev;
	assign flags.light_off_event = off_ev;

endmodule
